FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: hw/rtl/dfwb_pkg.sv
// Types and constants of the depth focus window block
package dfwb_pkg;
  localparam int unsigned DEPTH_BITS = 24;
  localparam int unsigned REG_W      = 24;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DIST_W     = 40;
  localparam int unsigned PROD_W     = DEPTH_BITS + REG_W;
  localparam int unsigned DEN_W      = PROD_W + 1;
  localparam int unsigned NUM_W      = 2 * REG_W + DEPTH_BITS;
  localparam int unsigned OFF_W      = REG_W + 2;
  localparam int unsigned SCL_W      = OFF_W + BYTE_W;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR   = 2'd0,
    REG_FAR    = 2'd1,
    REG_CENTER = 2'd2,
    REG_RANGE  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DEPTH_BITS-1:0] depth_sample;
    logic                  frame_end;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] depth_byte;
    logic              disabled;
    logic              frame_end_out;
  } out_beat_t;

  typedef struct packed {
    logic disabled;
    logic frame_end;
    logic force_max;
    logic force_zero;
  } ctl_t;
endpackage

FILE: hw/rtl/dfwb_front.sv
// Front stages: products, numerator and denominator, overflow check
module dfwb_front import dfwb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  in_beat_t              beat_i,
  input  logic [REG_W-1:0]      near_i,
  input  logic [REG_W-1:0]      far_i,
  input  logic                  disabled_i,
  output logic                  valid_o,
  output logic [DEN_W-1:0]      rem_o,
  output logic [DIST_W-1:0]     low_o,
  output logic [DEN_W-1:0]      den_o,
  output ctl_t                  ctl_o
);
  logic                v1_q, v2_q, v3_q;
  logic [PROD_W-1:0]   pf_q, pn_q;
  logic [2*REG_W-1:0]  a_q;
  ctl_t                c1_q, c2_q, c3_q;
  logic [NUM_W-1:0]    num_q;
  logic [DEN_W-1:0]    den2_q, den3_q, rem3_q;
  logic [DIST_W-1:0]   low3_q;
  logic [NUM_W-1:0]    num_d;
  logic [DEN_W-1:0]    den_d, hi_d;
  logic                sat_d;
  ctl_t                c1_d, c3_d;
  logic [DEPTH_BITS-1:0] inv_d;

  always_comb begin
    c1_d            = '0;
    c1_d.disabled   = disabled_i;
    c1_d.frame_end  = beat_i.frame_end;
    // distance from the far end of the depth range, kept at sample width
    inv_d = ~beat_i.depth_sample;
    num_d = {a_q, {DEPTH_BITS{1'b0}}} - NUM_W'(a_q);
    den_d = DEN_W'(pf_q) + DEN_W'(pn_q);
    hi_d  = DEN_W'(num_q[NUM_W-1:DIST_W]);
    sat_d = (hi_d >= den2_q);
    c3_d  = c2_q;
    c3_d.force_max = (den2_q == '0) || sat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pf_q   <= far_i * inv_d;
      pn_q   <= near_i * beat_i.depth_sample;
      a_q    <= far_i * near_i;
      c1_q   <= c1_d;
      num_q  <= num_d;
      den2_q <= den_d;
      c2_q   <= c1_q;
      rem3_q <= hi_d;
      low3_q <= num_q[DIST_W-1:0];
      den3_q <= den2_q;
      c3_q   <= c3_d;
    end
  end

  assign valid_o = v3_q;
  assign rem_o   = rem3_q;
  assign low_o   = low3_q;
  assign den_o   = den3_q;
  assign ctl_o   = c3_q;
endmodule

FILE: hw/rtl/dfwb_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage
module dfwb_div_pipe import dfwb_pkg::*; #(
  parameter int unsigned DW = 49,
  parameter int unsigned QW = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] den_i,
  input  ctl_t          ctl_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output ctl_t          ctl_o
);
  logic [QW:1]          v_q;
  logic [DW-1:0]        rem_q [1:QW];
  logic [QW-1:0]        x_q   [1:QW];
  logic [DW-1:0]        den_q [1:QW];
  ctl_t                 ctl_q [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] x_in;
    logic [DW-1:0] den_in;
    ctl_t          ctl_in;
    logic [DW:0]   r2;
    logic          ge;
    logic [DW:0]   diff;

    if (k == 0) begin : g_head
      assign v_in   = valid_i;
      assign rem_in = rem_i;
      assign x_in   = low_i;
      assign den_in = den_i;
      assign ctl_in = ctl_i;
    end else begin : g_body
      assign v_in   = v_q[k];
      assign rem_in = rem_q[k];
      assign x_in   = x_q[k];
      assign den_in = den_q[k];
      assign ctl_in = ctl_q[k];
    end

    always_comb begin
      r2   = {rem_in, x_in[QW-1]};
      diff = r2 - {1'b0, den_in};
      ge   = (r2 >= {1'b0, den_in});
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[DW-1:0] : r2[DW-1:0];
        x_q[k+1]   <= {x_in[QW-2:0], ge};
        den_q[k+1] <= den_in;
        ctl_q[k+1] <= ctl_in;
      end
    end
  end

  assign valid_o = v_q[QW];
  assign quot_o  = x_q[QW];
  assign ctl_o   = ctl_q[QW];
endmodule

FILE: hw/rtl/dfwb_window.sv
// Focus window compare and offset scaling ahead of the byte divider
module dfwb_window import dfwb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [DIST_W-1:0]  dist_i,
  input  ctl_t               ctl_i,
  input  logic [REG_W-1:0]   center_i,
  input  logic [REG_W-1:0]   range_i,
  output logic               valid_o,
  output logic [OFF_W-1:0]   rem_o,
  output logic [BYTE_W-1:0]  low_o,
  output ctl_t               ctl_o
);
  logic               v1_q, v2_q;
  logic [OFF_W-1:0]   off_q;
  ctl_t               c1_q, c2_q, c1_d;
  logic [SCL_W-1:0]   prod_q;
  logic [REG_W:0]     win_end;
  logic               start_pos, at_low, at_high;
  logic [OFF_W-1:0]   off_d;
  logic [SCL_W-1:0]   prod_d;

  always_comb begin
    win_end   = {1'b0, center_i} + {1'b0, range_i};
    start_pos = (center_i >= range_i);
    at_low    = start_pos && (dist_i <= DIST_W'(center_i - range_i));
    at_high   = (dist_i >= DIST_W'(win_end));
    off_d     = dist_i[OFF_W-1:0] + OFF_W'(range_i) - OFF_W'(center_i);
    c1_d            = ctl_i;
    c1_d.force_zero = ctl_i.disabled || (!ctl_i.force_max && at_low);
    c1_d.force_max  = !ctl_i.disabled && (ctl_i.force_max || at_high);
    prod_d = {off_q, {BYTE_W{1'b0}}} - SCL_W'(off_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      off_q  <= off_d;
      c1_q   <= c1_d;
      prod_q <= prod_d;
      c2_q   <= c1_q;
    end
  end

  assign valid_o = v2_q;
  assign rem_o   = prod_q[SCL_W-1:BYTE_W];
  assign low_o   = prod_q[BYTE_W-1:0];
  assign ctl_o   = c2_q;
endmodule

FILE: hw/rtl/depth_focus_window_to_byte.sv
// Top level: depth sample to focus-window byte, full-rate pipeline
// Accepts one depth sample per clock unless the output beat is held and returns
// one byte per sample, in order, through 3 front stages, 40 distance divider
// stages, 2 window stages, 8 byte divider stages and an output register; both
// dividers give one quotient bit per stage. The whole pipeline advances together
// and halts while the output beat waits. Users must write registers through the
// plain write port only while no beat is in flight; the block does not check it.
`include "assert_macros.svh"
module depth_focus_window_to_byte import dfwb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [REG_W-1:0]      cfg_wdata_i
);
  logic [REG_W-1:0]  near_q, far_q, center_q, range_q;
  logic              en;
  logic              out_valid_q;
  out_beat_t         out_q, out_d;

  logic              f_valid;
  logic [DEN_W-1:0]  f_rem, f_den;
  logic [DIST_W-1:0] f_low;
  ctl_t              f_ctl;

  logic              d_valid;
  logic [DIST_W-1:0] lin_dist;
  ctl_t              d_ctl;

  logic              w_valid;
  logic [OFF_W-1:0]  w_rem;
  logic [BYTE_W-1:0] w_low;
  ctl_t              w_ctl;

  logic              b_valid;
  logic [BYTE_W-1:0] b_quot;
  ctl_t              b_ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q   <= REG_W'(1024);
      far_q    <= REG_W'(524288);
      center_q <= REG_W'(262144);
      range_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_NEAR:   near_q   <= cfg_wdata_i;
        REG_FAR:    far_q    <= cfg_wdata_i;
        REG_CENTER: center_q <= cfg_wdata_i;
        REG_RANGE:  range_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // advance everything unless the output beat is held
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  dfwb_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .beat_i(in_data_i),
    .near_i(near_q), .far_i(far_q), .disabled_i(range_q == '0),
    .valid_o(f_valid), .rem_o(f_rem), .low_o(f_low), .den_o(f_den), .ctl_o(f_ctl)
  );

  dfwb_div_pipe #(.DW(DEN_W), .QW(DIST_W)) u_dist_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(f_valid), .rem_i(f_rem), .low_i(f_low), .den_i(f_den), .ctl_i(f_ctl),
    .valid_o(d_valid), .quot_o(lin_dist), .ctl_o(d_ctl)
  );

  dfwb_window u_window (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(d_valid), .dist_i(lin_dist), .ctl_i(d_ctl),
    .center_i(center_q), .range_i(range_q),
    .valid_o(w_valid), .rem_o(w_rem), .low_o(w_low), .ctl_o(w_ctl)
  );

  dfwb_div_pipe #(.DW(OFF_W), .QW(BYTE_W)) u_byte_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(w_valid), .rem_i(w_rem), .low_i(w_low),
    .den_i({1'b0, range_q, 1'b0}), .ctl_i(w_ctl),
    .valid_o(b_valid), .quot_o(b_quot), .ctl_o(b_ctl)
  );

  always_comb begin
    out_d.disabled      = b_ctl.disabled;
    out_d.frame_end_out = b_ctl.frame_end;
    if (b_ctl.force_zero) begin
      out_d.depth_byte = '0;
    end else if (b_ctl.force_max) begin
      out_d.depth_byte = '1;
    end else begin
      out_d.depth_byte = b_quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= b_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPL(a_dis_zero, clk_i, rst_ni, (out_valid_q && out_q.disabled) |-> (out_q.depth_byte == '0), "disabled beat carries nonzero byte")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, (out_valid_q && !out_ready_i), (out_valid_q && $stable(out_q)), "stalled output beat changed")
  `ASSERT_IMPL(a_dis_range, clk_i, rst_ni, (b_valid && en && range_q != '0) |-> !b_ctl.disabled, "disabled flag with nonzero range")
endmodule

FILE: bench/dfwb_checker.sv
// Checker: predicts the focus-window byte of each sample beat and compares results
`timescale 1ns / 100ps
module dfwb_checker import dfwb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_beat_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_beat_t        out_data_i,
  input  logic             cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0] cfg_wdata_i,
  output int               fail_cnt_o,
  output int               pending_o
);
  logic [REG_W-1:0] near_q, far_q, center_q, range_q;
  out_beat_t byte_fifo[$];

  function automatic out_beat_t focus_byte(in_beat_t b);
    out_beat_t r;
    logic [DEPTH_BITS-1:0] maxv;
    logic [127:0] num, den, lin_dist;
    logic [63:0] wend, wstart, off;
    logic start_pos;
    maxv = '1;
    r.frame_end_out = b.frame_end;
    r.disabled = 1'b0;
    den = 128'(far_q) * 128'(maxv - b.depth_sample) + 128'(near_q) * 128'(b.depth_sample);
    if (range_q == 0) begin
      r.disabled = 1'b1;
      r.depth_byte = 8'd0;
    end else if (den == 0) begin
      r.depth_byte = 8'd255;
    end else begin
      num = 128'(far_q) * 128'(near_q) * 128'(maxv);
      lin_dist = num / den;
      if (lin_dist > 128'((64'd1 << 40) - 1)) lin_dist = 128'((64'd1 << 40) - 1);
      wend = 64'(center_q) + 64'(range_q);
      start_pos = center_q >= range_q;
      wstart = start_pos ? 64'(center_q) - 64'(range_q) : 64'd0;
      if (start_pos && lin_dist[63:0] <= wstart) r.depth_byte = 8'd0;
      else if (lin_dist[63:0] >= wend) r.depth_byte = 8'd255;
      else begin
        off = lin_dist[63:0] + 64'(range_q) - 64'(center_q);
        r.depth_byte = 8'((off * 64'd255) / (64'd2 * 64'(range_q)));
      end
    end
    return r;
  endfunction

  assign pending_o = byte_fifo.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      near_q <= 24'd1024;
      far_q <= 24'd524288;
      center_q <= 24'd262144;
      range_q <= 24'd0;
      fail_cnt_o <= 0;
      byte_fifo.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_NEAR: near_q <= cfg_wdata_i;
          REG_FAR: far_q <= cfg_wdata_i;
          REG_CENTER: center_q <= cfg_wdata_i;
          REG_RANGE: range_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) byte_fifo.push_back(focus_byte(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (byte_fifo.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_data_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = byte_fifo.pop_front();
          if (want !== out_data_i) begin
            $display("%0t: mismatch expected byte=%0d dis=%b fe=%b actual byte=%0d dis=%b fe=%b",
                     $time, want.depth_byte, want.disabled, want.frame_end_out,
                     out_data_i.depth_byte, out_data_i.disabled, out_data_i.frame_end_out);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end
endmodule

FILE: bench/tb_depth_focus_window_to_byte.sv
// Testbench top: stimulus, register phases and verdict for the focus-window block
`timescale 1ns / 100ps
module tb_depth_focus_window_to_byte;
  import dfwb_pkg::*;

  localparam int LATENCY = 54;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_beat_t in_data_i;
  out_beat_t out_data_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0] cfg_wdata_i;
  int fail_cnt, pending;
  int send_idle_pct, recv_idle_pct, hold_off_cycles;
  longint cycle_cnt;

  depth_focus_window_to_byte i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  dfwb_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [REG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drop valid, then wait until every accepted beat has come back
  task automatic drain_all();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_sample(logic [DEPTH_BITS-1:0] s, logic fe);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{depth_sample: s, frame_end: fe};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [DEPTH_BITS-1:0] rand_sample();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return DEPTH_BITS'($urandom_range(255));
      3: return ~DEPTH_BITS'($urandom_range(255));
      default: return DEPTH_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_reg();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return REG_W'($urandom_range(1 << 16));
      default: return REG_W'($urandom);
    endcase
  endfunction

  // Pick registers so most samples fall inside a window around their distance
  task automatic random_setting();
    logic [REG_W-1:0] n, f;
    n = ($urandom_range(7) == 0) ? rand_reg() : REG_W'($urandom_range(1 << 12));
    f = ($urandom_range(7) == 0) ? rand_reg() : REG_W'(n + $urandom_range(1 << 20));
    write_reg(REG_NEAR, n);
    write_reg(REG_FAR, f);
    write_reg(REG_CENTER, ($urandom_range(7) == 0) ? rand_reg() :
              REG_W'(n + $urandom_range(32'(f - n) + 1)));
    write_reg(REG_RANGE, ($urandom_range(9) == 0) ? '0 :
              ($urandom_range(7) == 0) ? rand_reg() : REG_W'($urandom_range(1 << 16) + 1));
  endtask

  initial begin
    logic [DEPTH_BITS-1:0] s;
    int n_items;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_NEAR;
    cfg_wdata_i = '0;
    cycle_cnt = 0;
    hold_off_cycles = 0;
    send_idle_pct = 32;
    recv_idle_pct = 45;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: disabled at reset, then extremes and zero denominators
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    drain_all();
    write_reg(REG_RANGE, 24'd65536);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    send_sample(24'h800000, 1'b0);
    send_sample(24'hFF0000, 1'b1);
    drain_all();
    write_reg(REG_FAR, '0);
    write_reg(REG_CENTER, 24'd100);
    write_reg(REG_RANGE, 24'd1000);
    send_sample('0, 1'b0);
    send_sample(24'd1, 1'b1);
    drain_all();
    write_reg(REG_NEAR, '0);
    write_reg(REG_FAR, '1);
    send_sample('1, 1'b0);
    send_sample(24'd5, 1'b0);
    drain_all();
    write_reg(REG_NEAR, '1);
    write_reg(REG_FAR, 24'd256);
    write_reg(REG_CENTER, '1);
    write_reg(REG_RANGE, '1);
    for (int i = 0; i < 6; i++) send_sample(rand_sample(), i[0]);
    drain_all();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 45 : 0;
      recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 32 : 0;
      for (int k = 0; k < 9; k++) begin
        random_setting();
        n_items = 28;
        // long receiver hold-off with enough beats to fill the pipeline
        if (ph == 0 && k == 1) begin
          hold_off_cycles = 300;
          n_items = 90;
        end
        for (int i = 0; i < n_items; i++) begin
          s = rand_sample();
          send_sample(s, 1'($urandom));
        end
        // sender pauses until every result is back before the next setting
        drain_all();
      end
    end

    drain_all();
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
